// File: rtl/csc_pkg.sv
// shared types and codes for the circle to segment contact block
package csc_pkg;

  localparam logic [1:0] FEAT_START    = 2'd0;
  localparam logic [1:0] FEAT_END      = 2'd1;
  localparam logic [1:0] FEAT_INTERIOR = 2'd2;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  feature;
    logic [15:0] tag;
    logic [30:0] rad;
    logic [57:0] r2;
    logic [61:0] cr_mag;
    logic [61:0] len2;
    logic [61:0] d2;
    logic [60:0] nx_sq;
    logic [60:0] ny_sq;
    logic        nx_neg;
    logic        ny_neg;
    logic        nzero;
    logic [61:0] nlen;
  } csc_entry_t;

  typedef struct packed {
    logic       hit;
    csc_entry_t ent;
  } csc_mid_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] pen;
    logic [1:0]  feature;
    logic [15:0] tag;
    logic        nx_neg;
    logic        ny_neg;
    logic        nzero;
  } csc_tail_t;

endpackage

// File: rtl/csc_div.sv
// pipelined restoring divider, one quotient bit per stage
module csc_div #(
  parameter int NW = 124,
  parameter int DW = 62,
  parameter int Q  = 58,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [Q-1:0]  out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);
  localparam int HW = NW - Q;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [HW-1:0] hi;
  logic [CW-1:0] hi_c, den_c;

  logic          v_r    [0:Q-1];
  logic [DW-1:0] rem_r  [0:Q-1];
  logic [Q-1:0]  low_r  [0:Q-1];
  logic [Q-1:0]  quo_r  [0:Q-1];
  logic [DW-1:0] den_r  [0:Q-1];
  logic          ovf_r  [0:Q-1];
  logic [SW-1:0] side_r [0:Q-1];

  logic          s_v    [0:Q-1];
  logic [DW-1:0] s_rem  [0:Q-1];
  logic [Q-1:0]  s_low  [0:Q-1];
  logic [Q-1:0]  s_quo  [0:Q-1];
  logic [DW-1:0] s_den  [0:Q-1];
  logic          s_ovf  [0:Q-1];
  logic [SW-1:0] s_side [0:Q-1];

  logic [DW-1:0] rem_nxt [0:Q-1];
  logic [Q-1:0]  quo_nxt [0:Q-1];

  assign hi    = in_num[NW-1:Q];
  assign hi_c  = CW'(hi);
  assign den_c = CW'(in_den);

  always_comb begin
    s_v[0]    = in_valid;
    s_rem[0]  = DW'(hi);
    s_low[0]  = in_num[Q-1:0];
    s_quo[0]  = '0;
    s_den[0]  = in_den;
    s_ovf[0]  = (hi_c >= den_c);
    s_side[0] = in_side;
    for (int i = 1; i < Q; i++) begin
      s_v[i]    = v_r[i-1];
      s_rem[i]  = rem_r[i-1];
      s_low[i]  = low_r[i-1];
      s_quo[i]  = quo_r[i-1];
      s_den[i]  = den_r[i-1];
      s_ovf[i]  = ovf_r[i-1];
      s_side[i] = side_r[i-1];
    end
  end

  always_comb begin
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    for (int i = 0; i < Q; i++) begin
      t          = {s_rem[i], s_low[i][Q-1]};
      diff       = t - {1'b0, s_den[i]};
      ge         = (t >= {1'b0, s_den[i]});
      rem_nxt[i] = ge ? diff[DW-1:0] : t[DW-1:0];
      quo_nxt[i] = {s_quo[i][Q-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q; i++) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= s_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q; i++) begin
      rem_r[i]  <= rem_nxt[i];
      low_r[i]  <= s_low[i] << 1;
      quo_r[i]  <= quo_nxt[i];
      den_r[i]  <= s_den[i];
      ovf_r[i]  <= s_ovf[i];
      side_r[i] <= s_side[i];
    end
  end

  assign out_valid = v_r[Q-1];
  assign out_quo   = quo_r[Q-1];
  assign out_ovf   = ovf_r[Q-1];
  assign out_side  = side_r[Q-1];

endmodule

// File: rtl/csc_sqrt.sv
// pipelined integer square root, one root bit per stage
module csc_sqrt #(
  parameter int W  = 62,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [W-1:0]    in_val,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W/2-1:0]  out_root,
  output logic [SW-1:0]   out_side
);
  localparam int R = W / 2;

  logic          v_r    [0:R-1];
  logic [R:0]    rem_r  [0:R-1];
  logic [R-1:0]  root_r [0:R-1];
  logic [W-1:0]  val_r  [0:R-1];
  logic [SW-1:0] side_r [0:R-1];

  logic          s_v    [0:R-1];
  logic [R:0]    s_rem  [0:R-1];
  logic [R-1:0]  s_root [0:R-1];
  logic [W-1:0]  s_val  [0:R-1];
  logic [SW-1:0] s_side [0:R-1];

  logic [R:0]    rem_nxt  [0:R-1];
  logic [R-1:0]  root_nxt [0:R-1];

  always_comb begin
    s_v[0]    = in_valid;
    s_rem[0]  = '0;
    s_root[0] = '0;
    s_val[0]  = in_val;
    s_side[0] = in_side;
    for (int i = 1; i < R; i++) begin
      s_v[i]    = v_r[i-1];
      s_rem[i]  = rem_r[i-1];
      s_root[i] = root_r[i-1];
      s_val[i]  = val_r[i-1];
      s_side[i] = side_r[i-1];
    end
  end

  always_comb begin
    logic [R+2:0] t;
    logic [R+2:0] trial;
    logic [R+2:0] diff;
    logic         ge;
    for (int i = 0; i < R; i++) begin
      t           = {s_rem[i], s_val[i][W-1:W-2]};
      trial       = (R+3)'({s_root[i], 2'b01});
      diff        = t - trial;
      ge          = (t >= trial);
      rem_nxt[i]  = ge ? diff[R:0] : t[R:0];
      root_nxt[i] = {s_root[i][R-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < R; i++) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= s_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < R; i++) begin
      rem_r[i]  <= rem_nxt[i];
      root_r[i] <= root_nxt[i];
      val_r[i]  <= s_val[i] << 2;
      side_r[i] <= s_side[i];
    end
  end

  assign out_valid = v_r[R-1];
  assign out_root  = root_r[R-1];
  assign out_side  = side_r[R-1];

endmodule

// File: rtl/csc_queue.sv
// short register queue between the front and back ends
module csc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  csc_pkg::csc_entry_t          wr_data,
  input  logic                         rd_en,
  output csc_pkg::csc_entry_t          rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  import csc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  csc_entry_t    mem_r [0:DEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          do_rd;

  assign do_rd = rd_en && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;

endmodule

// File: rtl/csc_front.sv
// front end: takes requests, forms coarse vectors and products, classifies the feature
module csc_front #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [31:0]          in_seg_start_x,
  input  logic signed [31:0]          in_seg_start_y,
  input  logic signed [31:0]          in_seg_end_x,
  input  logic signed [31:0]          in_seg_end_y,
  input  logic signed [31:0]          in_centre_x,
  input  logic signed [31:0]          in_centre_y,
  input  logic [30:0]                 in_radius,
  input  logic [15:0]                 in_pair_tag,
  input  logic [$clog2(DEPTH+1)-1:0]  q_level,
  output logic                        busy,
  output logic                        q_push,
  output csc_pkg::csc_entry_t         q_data
);
  import csc_pkg::*;

  localparam int LW = $clog2(DEPTH+1);

  // floor of the 33 bit difference over four
  function automatic logic signed [30:0] coarse(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32:2];
  endfunction

  logic        accept;
  logic [LW:0] pending;

  // stage 1: coarse vectors
  logic               v1_r;
  logic signed [30:0] lx_r, ly_r, dx_r, dy_r, fx_r, fy_r;
  logic [28:0]        rc_r;
  logic [30:0]        rad1_r;
  logic [15:0]        tag1_r;

  // stage 2: products
  logic               v2_r;
  logic signed [61:0] p_dxlx_r, p_dyly_r, p_lxdy_r, p_lydx_r;
  logic signed [61:0] lx2_r, ly2_r, dx2_r, dy2_r, fx2_r, fy2_r;
  logic [57:0]        r2_r;
  logic [30:0]        rad2_r;
  logic [15:0]        tag2_r;
  logic               lx_neg_r, ly_neg_r, dx_neg_r, dy_neg_r, fx_neg_r, fy_neg_r;

  logic signed [62:0] proj, cr, cr_neg;
  logic [61:0]        len2, d2s, d2e;
  logic               cr_pos;

  assign pending = (LW+1)'(q_level) + (LW+1)'(v1_r) + (LW+1)'(v2_r);
  assign busy    = (pending >= (LW+1)'(DEPTH));
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    lx_r   <= coarse(in_seg_end_x, in_seg_start_x);
    ly_r   <= coarse(in_seg_end_y, in_seg_start_y);
    dx_r   <= coarse(in_centre_x, in_seg_start_x);
    dy_r   <= coarse(in_centre_y, in_seg_start_y);
    fx_r   <= coarse(in_centre_x, in_seg_end_x);
    fy_r   <= coarse(in_centre_y, in_seg_end_y);
    rc_r   <= in_radius[30:2];
    rad1_r <= in_radius;
    tag1_r <= in_pair_tag;
  end

  always_ff @(posedge clk) begin
    p_dxlx_r <= dx_r * lx_r;
    p_dyly_r <= dy_r * ly_r;
    p_lxdy_r <= lx_r * dy_r;
    p_lydx_r <= ly_r * dx_r;
    lx2_r    <= lx_r * lx_r;
    ly2_r    <= ly_r * ly_r;
    dx2_r    <= dx_r * dx_r;
    dy2_r    <= dy_r * dy_r;
    fx2_r    <= fx_r * fx_r;
    fy2_r    <= fy_r * fy_r;
    r2_r     <= rc_r * rc_r;
    rad2_r   <= rad1_r;
    tag2_r   <= tag1_r;
    lx_neg_r <= lx_r[30];
    ly_neg_r <= ly_r[30];
    dx_neg_r <= dx_r[30];
    dy_neg_r <= dy_r[30];
    fx_neg_r <= fx_r[30];
    fy_neg_r <= fy_r[30];
  end

  always_comb begin
    proj   = 63'(p_dxlx_r) + 63'(p_dyly_r);
    cr     = 63'(p_lxdy_r) - 63'(p_lydx_r);
    cr_neg = -cr;
    cr_pos = !cr[62] && (cr != '0);
    len2   = lx2_r[61:0] + ly2_r[61:0];
    d2s    = dx2_r[61:0] + dy2_r[61:0];
    d2e    = fx2_r[61:0] + fy2_r[61:0];

    q_data.tag    = tag2_r;
    q_data.rad    = rad2_r;
    q_data.r2     = r2_r;
    q_data.cr_mag = cr[62] ? cr_neg[61:0] : cr[61:0];
    q_data.len2   = len2;

    if (proj[62] || (proj == '0)) begin
      q_data.feature = FEAT_START;
      q_data.d2      = d2s;
      q_data.nx_sq   = dx2_r[60:0];
      q_data.ny_sq   = dy2_r[60:0];
      q_data.nx_neg  = dx_neg_r;
      q_data.ny_neg  = dy_neg_r;
      q_data.nzero   = (d2s == '0);
      q_data.nlen    = d2s;
    end else if (proj[61:0] >= len2) begin
      q_data.feature = FEAT_END;
      q_data.d2      = d2e;
      q_data.nx_sq   = fx2_r[60:0];
      q_data.ny_sq   = fy2_r[60:0];
      q_data.nx_neg  = fx_neg_r;
      q_data.ny_neg  = fy_neg_r;
      q_data.nzero   = (d2e == '0);
      q_data.nlen    = d2e;
    end else begin
      // normal runs along the segment perpendicular, side picked by the cross sign
      q_data.feature = FEAT_INTERIOR;
      q_data.d2      = '0;
      q_data.nx_sq   = ly2_r[60:0];
      q_data.ny_sq   = lx2_r[60:0];
      q_data.nx_neg  = cr_pos ? !ly_neg_r : ly_neg_r;
      q_data.ny_neg  = cr_pos ? lx_neg_r : !lx_neg_r;
      q_data.nzero   = (cr == '0);
      q_data.nlen    = len2;
    end
  end

  assign q_push = v2_r;

endmodule

// File: rtl/csc_back.sv
// back end: distance, hit test, penetration and unit normal
module csc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  csc_pkg::csc_entry_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  output logic                out_hit,
  output logic signed [15:0]  out_normal_x,
  output logic signed [15:0]  out_normal_y,
  output logic [30:0]         out_penetration,
  output logic [1:0]          out_feature,
  output logic [15:0]         out_tag_out
);
  import csc_pkg::*;

  localparam int EW = $bits(csc_entry_t);
  localparam int MW = $bits(csc_mid_t);
  localparam int TW = $bits(csc_tail_t);

  function automatic logic signed [15:0] apply_sign(input logic [14:0] root, input logic neg);
    logic signed [15:0] m;
    m = 16'(root);
    return neg ? -m : m;
  endfunction

  // cross product squared in partial products
  logic        sq_v_r;
  csc_entry_t  sq_ent_r;
  logic [61:0] pp_hh_r, pp_hl_r, pp_ll_r;

  logic         c2_v_r;
  csc_entry_t   c2_ent_r;
  logic [123:0] c2_r;

  logic          dd_v, dd_ovf;
  logic [57:0]   dd_quo;
  logic [EW-1:0] dd_side;
  csc_entry_t    dd_ent;

  logic        hit_c, interior;
  logic [57:0] dist_c;
  logic        hs_v_r;
  csc_mid_t    hs_mid_r;
  logic [57:0] hs_dist_r;

  logic          ps_v;
  logic [30:0]   ps_root;
  logic [MW-1:0] ps_side;
  csc_mid_t      ps_mid;
  csc_tail_t     tail;

  logic [28:0]   nxd_quo, nyd_quo;
  logic          nyd_v;
  logic [TW-1:0] nyd_side;

  logic [14:0]   nxs_root, nys_root;
  logic          nys_v;
  logic [TW-1:0] nys_side;
  csc_tail_t     fin;

  logic               ov_r;
  logic               hit_r;
  logic signed [15:0] nx_r, ny_r;
  logic [30:0]        pen_r;
  logic [1:0]         feat_r;
  logic [15:0]        tag_r;

  assign q_pop = q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      hs_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      sq_v_r <= q_valid;
      c2_v_r <= sq_v_r;
      hs_v_r <= dd_v;
      ov_r   <= nys_v;
    end
  end

  always_ff @(posedge clk) begin
    sq_ent_r <= q_data;
    pp_hh_r  <= q_data.cr_mag[61:31] * q_data.cr_mag[61:31];
    pp_hl_r  <= q_data.cr_mag[61:31] * q_data.cr_mag[30:0];
    pp_ll_r  <= q_data.cr_mag[30:0] * q_data.cr_mag[30:0];
    c2_ent_r <= sq_ent_r;
    c2_r     <= (124'(pp_hh_r) << 62) + (124'(pp_hl_r) << 32) + 124'(pp_ll_r);
  end

  // squared interior distance, cross squared over segment length squared
  csc_div #(.NW(124), .DW(62), .Q(58), .SW(EW)) u_div_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c2_v_r),
    .in_num   (c2_r),
    .in_den   (c2_ent_r.len2),
    .in_side  (c2_ent_r),
    .out_valid(dd_v),
    .out_quo  (dd_quo),
    .out_ovf  (dd_ovf),
    .out_side (dd_side)
  );

  assign dd_ent   = dd_side;
  assign interior = (dd_ent.feature == FEAT_INTERIOR);

  always_comb begin
    if (interior) begin
      hit_c  = !dd_ovf && (dd_quo < dd_ent.r2);
      dist_c = dd_quo;
    end else begin
      hit_c  = (dd_ent.d2 < 62'(dd_ent.r2));
      dist_c = dd_ent.d2[57:0];
    end
  end

  always_ff @(posedge clk) begin
    hs_mid_r.hit <= hit_c;
    hs_mid_r.ent <= dd_ent;
    hs_dist_r    <= dist_c;
  end

  // distance in input units
  csc_sqrt #(.W(62), .SW(MW)) u_sqrt_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (hs_v_r),
    .in_val   ({hs_dist_r, 4'b0000}),
    .in_side  (hs_mid_r),
    .out_valid(ps_v),
    .out_root (ps_root),
    .out_side (ps_side)
  );

  assign ps_mid = ps_side;

  always_comb begin
    tail.hit     = ps_mid.hit;
    tail.pen     = ps_mid.ent.rad - ps_root;
    tail.feature = ps_mid.ent.feature;
    tail.tag     = ps_mid.ent.tag;
    tail.nx_neg  = ps_mid.ent.nx_neg;
    tail.ny_neg  = ps_mid.ent.ny_neg;
    tail.nzero   = ps_mid.ent.nzero;
  end

  // squared normal components scaled by 2^28
  csc_div #(.NW(89), .DW(62), .Q(29), .SW(1)) u_div_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ps_v),
    .in_num   ({ps_mid.ent.nx_sq, 28'd0}),
    .in_den   (ps_mid.ent.nlen),
    .in_side  (1'b0),
    .out_valid(),
    .out_quo  (nxd_quo),
    .out_ovf  (),
    .out_side ()
  );

  csc_div #(.NW(89), .DW(62), .Q(29), .SW(TW)) u_div_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ps_v),
    .in_num   ({ps_mid.ent.ny_sq, 28'd0}),
    .in_den   (ps_mid.ent.nlen),
    .in_side  (tail),
    .out_valid(nyd_v),
    .out_quo  (nyd_quo),
    .out_ovf  (),
    .out_side (nyd_side)
  );

  csc_sqrt #(.W(30), .SW(1)) u_sqrt_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (nyd_v),
    .in_val   ({1'b0, nxd_quo}),
    .in_side  (1'b0),
    .out_valid(),
    .out_root (nxs_root),
    .out_side ()
  );

  csc_sqrt #(.W(30), .SW(TW)) u_sqrt_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (nyd_v),
    .in_val   ({1'b0, nyd_quo}),
    .in_side  (nyd_side),
    .out_valid(nys_v),
    .out_root (nys_root),
    .out_side (nys_side)
  );

  assign fin = nys_side;

  always_ff @(posedge clk) begin
    hit_r  <= fin.hit;
    feat_r <= fin.feature;
    tag_r  <= fin.tag;
    pen_r  <= fin.hit ? fin.pen : '0;
    if (fin.hit && !fin.nzero) begin
      nx_r <= apply_sign(nxs_root, fin.nx_neg);
      ny_r <= apply_sign(nys_root, fin.ny_neg);
    end else begin
      nx_r <= '0;
      ny_r <= '0;
    end
  end

  assign out_valid       = ov_r;
  assign out_hit         = hit_r;
  assign out_normal_x    = nx_r;
  assign out_normal_y    = ny_r;
  assign out_penetration = pen_r;
  assign out_feature     = feat_r;
  assign out_tag_out     = tag_r;

endmodule

// File: rtl/circle_segment_contact.sv
// top level of the circle to segment contact unit
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  request  | start / busy       | in_seg_start_*, in_seg_end_*, in_centre_*,
//           |                    | in_radius, in_pair_tag
//  result   | out_valid (strobe) | out_hit, out_normal_x/y, out_penetration,
//           |                    | out_feature, out_tag_out
//
// one request a clock while busy is low; the path from the accepting edge to
// the edge that takes the result runs through the pipelined interior
// distance divider (58 stages), distance root (31), normal dividers (29) and
// normal roots (15)
// synchronous active-low reset empties every stage and the queue
// results cannot be held off; busy only rises if the queue plus the two front
// stages would run out of room, which with the back end draining every cycle
// does not happen in normal use
module circle_segment_contact #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_seg_start_x,
  input  logic signed [31:0] in_seg_start_y,
  input  logic signed [31:0] in_seg_end_x,
  input  logic signed [31:0] in_seg_end_y,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic [30:0]        in_radius,
  input  logic [15:0]        in_pair_tag,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic [30:0]        out_penetration,
  output logic [1:0]         out_feature,
  output logic [15:0]        out_tag_out
);
  import csc_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH+1);

  // front to queue
  logic        q_push;
  csc_entry_t  q_wr_data;
  // queue to back
  csc_entry_t  q_rd_data;
  logic        q_empty;
  logic        q_pop;
  logic [LW-1:0] q_level;

  // coarse grid, products and feature choice
  csc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_centre_x    (in_centre_x),
    .in_centre_y    (in_centre_y),
    .in_radius      (in_radius),
    .in_pair_tag    (in_pair_tag),
    .q_level        (q_level),
    .busy           (busy),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // decouples classification from the long arithmetic pipe
  csc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .level   (q_level)
  );

  // distance, hit, penetration and normal
  csc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (!q_empty),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_normal_x    (out_normal_x),
    .out_normal_y    (out_normal_y),
    .out_penetration (out_penetration),
    .out_feature     (out_feature),
    .out_tag_out     (out_tag_out)
  );

endmodule

// File: rtl/csc_checker.sv
// port level checks for the contact unit and their bind
module csc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic               out_hit,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic [30:0]        out_penetration
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result strobe or busy after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_normal_x == 16'sd0 && out_normal_y == 16'sd0
                              && out_penetration == 31'd0)
    else $error("miss with non-zero normal or penetration");

  a_hit_pen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_penetration != 31'd0)
    else $error("hit with zero penetration");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384
                  && out_normal_y <= 16'sd16384 && out_normal_y >= -16'sd16384)
    else $error("normal component outside unit range");

endmodule

bind circle_segment_contact csc_checker u_csc_checker (.*);

// File: tb/tb_top.sv
// testbench for the circle to segment contact unit: predictor, stimulus and result checks
`timescale 1ns / 1ps

module tb_top;
  import csc_pkg::*;

  // one contact request as the block sees it
  typedef struct {
    logic signed [31:0] sx, sy, ex, ey, cx, cy;
    logic [30:0]        rad;
    logic [15:0]        tag;
  } contact_req_t;

  // one contact result
  typedef struct {
    logic               hit;
    logic signed [15:0] nx, ny;
    logic [30:0]        pen;
    logic [1:0]         feat;
    logic [15:0]        tag;
  } contact_res_t;

  localparam int LATENCY   = 140;
  localparam int STALL_MAX = 20000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y;
  logic signed [31:0] in_centre_x, in_centre_y;
  logic [30:0]        in_radius;
  logic [15:0]        in_pair_tag;
  logic               out_valid, out_hit;
  logic signed [15:0] out_normal_x, out_normal_y;
  logic [30:0]        out_penetration;
  logic [1:0]         out_feature;
  logic [15:0]        out_tag_out;

  contact_res_t expected_contacts[$];
  int  n_errors   = 0;
  int  n_requests = 0;
  int  n_results  = 0;
  int  n_hits     = 0;
  int  idle_count = 0;
  int  feat_seen[3] = '{0, 0, 0};

  circle_segment_contact DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg_start_x(in_seg_start_x), .in_seg_start_y(in_seg_start_y),
    .in_seg_end_x(in_seg_end_x), .in_seg_end_y(in_seg_end_y),
    .in_centre_x(in_centre_x), .in_centre_y(in_centre_y),
    .in_radius(in_radius), .in_pair_tag(in_pair_tag),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_penetration(out_penetration), .out_feature(out_feature),
    .out_tag_out(out_tag_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // floor square root of a 128-bit value, bit by bit
  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  res;
    logic [127:0] trial;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = {64'd0, res | (64'd1 << b)};
      if (trial * trial <= v) res = res | (64'd1 << b);
    end
    return res;
  endfunction

  // floor(16384 * a / sqrt(len2)), done as the root of an exact quotient
  function automatic logic [15:0] unit_part(logic [63:0] a, logic [63:0] len2);
    logic [127:0] num;
    if (len2 == 0) return '0;
    num = ({64'd0, a} * {64'd0, a}) << 28;
    return 16'(floor_root(num / {64'd0, len2}));
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [15:0] apply_sign(logic signed [63:0] s,
                                                    logic [15:0] m);
    if (s > 0) return $signed(m);
    if (s < 0) return -$signed(m);
    return '0;
  endfunction

  // coarse grid: 33-bit difference, floored shift by two (>>> on signed is floor)
  function automatic logic signed [63:0] coarse(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    return d >>> 2;
  endfunction

  function automatic contact_res_t predict_contact(contact_req_t r);
    contact_res_t       o;
    logic signed [63:0] lx, ly, dx, dy, ux, uy, proj, len2, cr;
    logic [63:0]        rc, r2, d2, pen;
    logic [127:0]       c2, lim;
    lx   = coarse(r.ex, r.sx);
    ly   = coarse(r.ey, r.sy);
    dx   = coarse(r.cx, r.sx);
    dy   = coarse(r.cy, r.sy);
    proj = dx * lx + dy * ly;
    len2 = lx * lx + ly * ly;
    rc   = {33'd0, r.rad} >> 2;
    r2   = rc * rc;
    o.hit = 1'b0; o.nx = '0; o.ny = '0; o.pen = '0; o.tag = r.tag;
    if (proj <= 0 || proj >= len2) begin
      ux = dx; uy = dy;
      o.feat = FEAT_START;
      if (proj > 0) begin
        o.feat = FEAT_END;
        ux = coarse(r.cx, r.ex);
        uy = coarse(r.cy, r.ey);
      end
      d2 = magnitude(ux) * magnitude(ux) + magnitude(uy) * magnitude(uy);
      if (d2 < r2) begin
        o.hit = 1'b1;
        pen   = {33'd0, r.rad} - floor_root({64'd0, d2} << 4);
        o.pen = pen[30:0];
        o.nx  = apply_sign(ux, unit_part(magnitude(ux), d2));
        o.ny  = apply_sign(uy, unit_part(magnitude(uy), d2));
      end
    end else begin
      cr     = lx * dy - ly * dx;
      c2     = {64'd0, magnitude(cr)} * {64'd0, magnitude(cr)};
      lim    = {64'd0, r2} * {64'd0, len2};
      o.feat = FEAT_INTERIOR;
      if (c2 < lim) begin
        d2    = 64'(c2 / {64'd0, len2});
        o.hit = 1'b1;
        pen   = {33'd0, r.rad} - floor_root({64'd0, d2} << 4);
        o.pen = pen[30:0];
        // interior normal is the segment perpendicular on the centre's side,
        // zero when the centre lies on the line
        o.nx  = apply_sign(cr < 0 ? ly : (cr > 0 ? -ly : 64'sd0),
                           unit_part(magnitude(ly), len2));
        o.ny  = apply_sign(cr < 0 ? -lx : (cr > 0 ? lx : 64'sd0),
                           unit_part(magnitude(lx), len2));
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- checker

  // results cannot be stalled, so every strobe is taken at the edge
  always @(posedge clk) begin
    contact_res_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected result tag %h", $time, out_tag_out);
        n_errors++;
      end else begin
        want = expected_contacts.pop_front();
        if (out_hit !== want.hit || out_normal_x !== want.nx ||
            out_normal_y !== want.ny || out_penetration !== want.pen ||
            out_feature !== want.feat || out_tag_out !== want.tag) begin
          $display("%0t: mismatch expected hit %b n (%0d,%0d) pen %0d feat %0d tag %h",
                   $time, want.hit, want.nx, want.ny, want.pen, want.feat, want.tag);
          $display("%0t:            actual hit %b n (%0d,%0d) pen %0d feat %0d tag %h",
                   $time, out_hit, out_normal_x, out_normal_y, out_penetration,
                   out_feature, out_tag_out);
          n_errors++;
        end
        if (want.hit) n_hits++;
        feat_seen[want.feat]++;
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) idle_count <= 0;
    else if (rst_n) idle_count <= idle_count + 1;
    if (idle_count > STALL_MAX) begin
      $display("[circle_segment_contact] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // mostly no gap at all, else a short gap, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_request(contact_req_t r, bit gaps = 1'b1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start          <= 1'b1;
    in_seg_start_x <= r.sx; in_seg_start_y <= r.sy;
    in_seg_end_x   <= r.ex; in_seg_end_y   <= r.ey;
    in_centre_x    <= r.cx; in_centre_y    <= r.cy;
    in_radius      <= r.rad;
    in_pair_tag    <= r.tag;
    do @(posedge clk); while (busy);
    expected_contacts.insert(expected_contacts.size(), predict_contact(r));
    n_requests++;
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    drop_start();
    while (expected_contacts.size() != 0) @(posedge clk);
  endtask

  function automatic contact_req_t make_req(int sx, int sy, int ex, int ey,
                                            int cx, int cy, int rad);
    contact_req_t r;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.cx = cx; r.cy = cy;
    r.rad = 31'(rad);
    r.tag = 16'($urandom);
    return r;
  endfunction

  // a near miss or a hit around a random segment, at a random scale
  function automatic contact_req_t near_req();
    contact_req_t r;
    int span, t;
    span  = 1 << $urandom_range(4, 28);
    r.sx  = $signed($urandom_range(0, 2 * span)) - span;
    r.sy  = $signed($urandom_range(0, 2 * span)) - span;
    r.ex  = r.sx + $signed($urandom_range(0, 2 * span)) - span;
    r.ey  = r.sy + $signed($urandom_range(0, 2 * span)) - span;
    t     = $urandom_range(0, 2);
    // centre near start, end or the midpoint
    r.cx  = (t == 0 ? r.sx : t == 1 ? r.ex : (r.sx >>> 1) + (r.ex >>> 1))
            + $signed($urandom_range(0, span)) - span / 2;
    r.cy  = (t == 0 ? r.sy : t == 1 ? r.ey : (r.sy >>> 1) + (r.ey >>> 1))
            + $signed($urandom_range(0, span)) - span / 2;
    r.rad = 31'($urandom_range(0, span));
    r.tag = 16'($urandom);
    return r;
  endfunction

  function automatic contact_req_t noise_req();
    contact_req_t r;
    r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
    r.cx = $urandom; r.cy = $urandom; r.rad = 31'($urandom); r.tag = 16'($urandom);
    return r;
  endfunction

  // field extremes, each feature, degenerate segment, zero radius, centre on segment
  task automatic test_directed();
    int mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    send_request(make_req(0, 0, 65536, 0, -4096, 0, 8192));
    send_request(make_req(0, 0, 65536, 0, 70000, 100, 16384));
    send_request(make_req(0, 0, 65536, 0, 30000, 5000, 16384));
    send_request(make_req(0, 0, 65536, 0, 30000, -5000, 16384));
    send_request(make_req(0, 0, 65536, 65536, 40000, 20000, 65536));
    send_request(make_req(0, 0, 65536, 0, 30000, 0, 16384));       // centre on the line
    send_request(make_req(100, 100, 65536, 0, 100, 100, 16384));   // on the start point
    send_request(make_req(100, 100, 65536, 0, 65536, 0, 16384));   // on the end point
    send_request(make_req(500, 500, 501, 502, 900, 900, 65536));   // same coarse point
    send_request(make_req(0, 0, 65536, 0, 30000, 0, 0));           // zero radius
    send_request(make_req(0, 0, 65536, 0, 30000, 0, 3));           // radius lost on grid
    send_request(make_req(mn, mn, mx, mx, mx, mn, mx));
    send_request(make_req(mx, mx, mn, mn, mn, mx, mx));
    send_request(make_req(mn, mx, mx, mn, 0, 0, mx));
    send_request(make_req(mn, mn, mn, mn, mx, mx, mx));
    send_request(make_req(mx, 0, mx, 0, mx, 0, mx));
    send_request(make_req(-1, -1, -1, -1, -1, -1, 1));
    send_request(make_req(0, 0, -65536, -65536, -40000, -20000, 65536));
    begin
      contact_req_t r;
      r = make_req(0, 0, 0, 0, 0, 0, 0);
      r.tag = 16'hffff;
      send_request(r);
      r.tag = 16'h0000;
      send_request(r);
    end
  endtask

  task automatic test_streaming(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) send_request(near_req(), (i % 200) >= 60);
      else send_request(noise_req(), (i % 200) >= 60);
    end
  endtask

  initial begin
    start          = 1'b0;
    rst_n          = 1'b0;
    in_seg_start_x = '0; in_seg_start_y = '0;
    in_seg_end_x   = '0; in_seg_end_y   = '0;
    in_centre_x    = '0; in_centre_y    = '0;
    in_radius      = '0;
    in_pair_tag    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_drained();                 // sender holds off until the pipe is empty
    test_streaming(700);
    wait_drained();
    test_streaming(730);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d hits", n_requests, n_results,
             n_hits);
    $display("nearest feature start %0d end %0d interior %0d", feat_seen[0],
             feat_seen[1], feat_seen[2]);
    if (n_errors == 0 && expected_contacts.size() == 0)
      $display("[circle_segment_contact] OK");
    else
      $display("[circle_segment_contact] ERROR");
    $finish;
  end

endmodule
